// ===== rtl/tufn_pkg.sv =====
// Shared types for the triangle unit face normal block.
// No dependencies.
`default_nettype none
package tufn_pkg;
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} cross_t;

	localparam int unsigned QUEUE_DEPTH = 2;
endpackage
`default_nettype wire

// ===== rtl/triangle_unit_face_normal.sv =====
// Top level of the triangle unit face normal block.
// Depends on tufn_pkg, tufn_front, tufn_queue and tufn_back.
//
// One face is taken in every clock cycle while busy is low. Each result appears on the
// result ports for one cycle with done high; the pipeline runs through the front part,
// the queue, the 16-stage square root and the 32-stage divider.
// The receiver cannot stall, so the back part drains the queue every cycle.
`default_nettype none
module triangle_unit_face_normal import tufn_pkg::*; #(
	parameter int unsigned FRAC_BITS = 12
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [15:0] a_x, a_y, a_z,
	input  wire logic signed [15:0] b_x, b_y, b_z,
	input  wire logic signed [15:0] c_x, c_y, c_z,
	output logic                    done,
	output logic signed [15:0]      normal_x,
	output logic signed [15:0]      normal_y,
	output logic signed [15:0]      normal_z,
	output logic                    zero_length
);
	logic   f_valid, q_empty, q_full;
	cross_t f_cross, q_head;

	assign busy = q_full;

	tufn_front u_front (
		.clk, .arst_n,
		.in_valid (start && !busy),
		.a_x, .a_y, .a_z, .b_x, .b_y, .b_z, .c_x, .c_y, .c_z,
		.out_valid(f_valid),
		.out_cross(f_cross)
	);

	tufn_queue u_queue (
		.clk, .arst_n,
		.push     (f_valid),
		.push_data(f_cross),
		.pop      (!q_empty),
		.empty    (q_empty),
		.full     (q_full),
		.head     (q_head)
	);

	tufn_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n,
		.in_valid(!q_empty),
		.in_cross(q_head),
		.done, .normal_x, .normal_y, .normal_z, .zero_length
	);
endmodule
`default_nettype wire

// ===== rtl/tufn_front.sv =====
// Front part: edge vectors and wrapped cross product of one face.
// Depends on tufn_pkg.
`default_nettype none
module tufn_front import tufn_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic signed [15:0] a_x, a_y, a_z,
	input  wire logic signed [15:0] b_x, b_y, b_z,
	input  wire logic signed [15:0] c_x, c_y, c_z,
	output logic                    out_valid,
	output cross_t                  out_cross
);
	logic               v_s1, v_s2, v_s3;
	logic signed [15:0] ex_s1, ey_s1, ez_s1, fx_s1, fy_s1, fz_s1;
	logic signed [31:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	cross_t             cr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ex_s1 <= a_x - b_x;
		ey_s1 <= a_y - b_y;
		ez_s1 <= a_z - b_z;
		fx_s1 <= b_x - c_x;
		fy_s1 <= b_y - c_y;
		fz_s1 <= b_z - c_z;
		p0_s2 <= ey_s1 * fz_s1;
		p1_s2 <= fy_s1 * ez_s1;
		p2_s2 <= ez_s1 * fx_s1;
		p3_s2 <= fz_s1 * ex_s1;
		p4_s2 <= ex_s1 * fy_s1;
		p5_s2 <= fx_s1 * ey_s1;
		cr_s3.x <= p0_s2 - p1_s2;
		cr_s3.y <= p2_s2 - p3_s2;
		cr_s3.z <= p4_s2 - p5_s2;
	end

	assign out_valid = v_s3;
	assign out_cross = cr_s3;
endmodule
`default_nettype wire

// ===== rtl/tufn_queue.sv =====
// Short queue between the front and back parts.
// Depends on tufn_pkg.
`default_nettype none
module tufn_queue import tufn_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  cross_t      push_data,
	input  wire logic   pop,
	output logic        empty,
	output logic        full,
	output cross_t      head
);
	cross_t     mem_q [QUEUE_DEPTH];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'(QUEUE_DEPTH));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full)
				wr_q <= !wr_q;
			if (pop && !empty)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/tufn_back.sv =====
// Back part: length by pipelined square root, then pipelined division.
// Depends on tufn_pkg.
`default_nettype none
module tufn_back import tufn_pkg::*; #(
	parameter int unsigned FRAC_BITS = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  cross_t             in_cross,
	output logic               done,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic               zero_length
);
	localparam int unsigned SQ_STAGES  = 16;
	localparam int unsigned DIV_STAGES = 32;

	logic               v_s1, v_s2, v_s3;
	cross_t             cr_s1, cr_s2, cr_s3;
	logic signed [15:0] sx_s1, sy_s1, sz_s1;
	logic [30:0]        qx_s2, qy_s2, qz_s2;
	logic [31:0]        sum_s3;

	logic        rv_s   [SQ_STAGES+1];
	cross_t      rc_s   [SQ_STAGES+1];
	logic [31:0] rn_s   [SQ_STAGES+1];
	logic [16:0] rr_s   [SQ_STAGES+1];
	logic [15:0] rt_s   [SQ_STAGES+1];

	logic        dv_s   [DIV_STAGES+1];
	logic [2:0]  dsg_s  [DIV_STAGES+1];
	logic        dz_s   [DIV_STAGES+1];
	logic [15:0] dl_s   [DIV_STAGES+1];
	logic [31:0] dq_s   [3][DIV_STAGES+1];
	logic [15:0] dr_s   [3][DIV_STAGES+1];

	logic [31:0] mag [3];
	logic [31:0] cin [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		cr_s1 <= in_cross;
		sx_s1 <= 16'(in_cross.x >>> FRAC_BITS);
		sy_s1 <= 16'(in_cross.y >>> FRAC_BITS);
		sz_s1 <= 16'(in_cross.z >>> FRAC_BITS);
		cr_s2 <= cr_s1;
		qx_s2 <= 31'(32'(sx_s1) * 32'(sx_s1));
		qy_s2 <= 31'(32'(sy_s1) * 32'(sy_s1));
		qz_s2 <= 31'(32'(sz_s1) * 32'(sz_s1));
		cr_s3 <= cr_s2;
		sum_s3 <= 32'(qx_s2) + 32'(qy_s2) + 32'(qz_s2);
	end

	assign rv_s[0] = v_s3;
	assign rc_s[0] = cr_s3;
	assign rn_s[0] = sum_s3;
	assign rr_s[0] = '0;
	assign rt_s[0] = '0;

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
		logic [18:0] trial, rem;
		assign rem   = {rr_s[k], rn_s[k][31:30]};
		assign trial = {1'b0, rt_s[k], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				rv_s[k+1] <= 1'b0;
			else
				rv_s[k+1] <= rv_s[k];
		end
		always_ff @(posedge clk) begin
			rc_s[k+1] <= rc_s[k];
			rn_s[k+1] <= {rn_s[k][29:0], 2'b00};
			if (rem >= trial) begin
				rr_s[k+1] <= 17'(rem - trial);
				rt_s[k+1] <= {rt_s[k][14:0], 1'b1};
			end else begin
				rr_s[k+1] <= 17'(rem);
				rt_s[k+1] <= {rt_s[k][14:0], 1'b0};
			end
		end
	end

	assign cin[0] = rc_s[SQ_STAGES].x;
	assign cin[1] = rc_s[SQ_STAGES].y;
	assign cin[2] = rc_s[SQ_STAGES].z;
	assign dv_s[0]  = rv_s[SQ_STAGES];
	assign dl_s[0]  = rt_s[SQ_STAGES];
	assign dz_s[0]  = (rt_s[SQ_STAGES] == 16'd0);

	for (genvar c = 0; c < 3; c++) begin : g_mag
		assign mag[c]       = cin[c][31] ? 32'(-cin[c]) : cin[c];
		assign dsg_s[0][c]  = cin[c][31];
		assign dq_s[c][0]   = mag[c];
		assign dr_s[c][0]   = '0;
	end

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_s[j+1] <= 1'b0;
			else
				dv_s[j+1] <= dv_s[j];
		end
		always_ff @(posedge clk) begin
			dsg_s[j+1] <= dsg_s[j];
			dz_s[j+1]  <= dz_s[j];
			dl_s[j+1]  <= dl_s[j];
		end
		for (genvar c = 0; c < 3; c++) begin : g_lane
			logic [16:0] t;
			assign t = {dr_s[c][j], dq_s[c][j][31]};
			always_ff @(posedge clk) begin
				if (t >= {1'b0, dl_s[j]}) begin
					dr_s[c][j+1] <= 16'(t - {1'b0, dl_s[j]});
					dq_s[c][j+1] <= {dq_s[c][j][30:0], 1'b1};
				end else begin
					dr_s[c][j+1] <= t[15:0];
					dq_s[c][j+1] <= {dq_s[c][j][30:0], 1'b0};
				end
			end
		end
	end

	logic [15:0] res [3];
	for (genvar c = 0; c < 3; c++) begin : g_res
		assign res[c] = dz_s[DIV_STAGES] ? 16'd0 :
			(dsg_s[DIV_STAGES][c] ? 16'(-dq_s[c][DIV_STAGES][15:0])
			                      : dq_s[c][DIV_STAGES][15:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done        <= 1'b0;
			zero_length <= 1'b0;
		end else begin
			done        <= dv_s[DIV_STAGES];
			zero_length <= dv_s[DIV_STAGES] && dz_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		normal_x <= res[0];
		normal_y <= res[1];
		normal_z <= res[2];
	end
endmodule
`default_nettype wire

// ===== rtl/tufn_checker.sv =====
// Port-level checks for the triangle unit face normal block, with its bind.
// Depends on triangle_unit_face_normal.
`default_nettype none
module tufn_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [15:0] normal_x,
	input wire logic [15:0] normal_y,
	input wire logic [15:0] normal_z,
	input wire logic        zero_length
);
	a_zero_norm: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_length |-> normal_x == 16'd0 && normal_y == 16'd0 && normal_z == 16'd0)
		else $error("Zero length with nonzero normal.");
	a_flag_done: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !zero_length)
		else $error("Zero length flag without a result.");
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("Queue filled although the back part drains it.");
endmodule

bind triangle_unit_face_normal tufn_checker u_checker (
	.clk, .arst_n, .busy, .done, .normal_x, .normal_y, .normal_z, .zero_length
);
`default_nettype wire

// ===== tb/sv/tb_triangle_unit_face_normal_checker.sv =====
// Checker for the triangle unit face normal block: watches accepted faces,
// predicts each unit normal and compares it with the result strobed on done.
// Depends only on the ports of triangle_unit_face_normal.
module tb_triangle_unit_face_normal_checker #(
	parameter int unsigned FRAC_BITS = 12
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic signed [15:0] a_x, a_y, a_z,
	input  wire logic signed [15:0] b_x, b_y, b_z,
	input  wire logic signed [15:0] c_x, c_y, c_z,
	input  wire logic               done,
	input  wire logic signed [15:0] normal_x,
	input  wire logic signed [15:0] normal_y,
	input  wire logic signed [15:0] normal_z,
	input  wire logic               zero_length,
	output int                      fail_count,
	output int                      pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               zl;
	} normal_t;

	normal_t normal_queue[$];

	function automatic logic [31:0] floor_sqrt(logic [31:0] n);
		logic [31:0] root;
		logic [31:0] trial;
		root = 0;
		for (int i = 15; i >= 0; i--) begin
			trial = root | (32'd1 << i);
			if (64'(trial) * 64'(trial) <= 64'(n))
				root = trial;
		end
		return root;
	endfunction

	function automatic normal_t face_normal(logic signed [15:0] ax, ay, az,
			bx, by, bz, cx, cy, cz);
		logic signed [15:0] ex, ey, ez, fx, fy, fz;
		logic signed [31:0] kx, ky, kz;
		logic signed [15:0] sx, sy, sz;
		logic [31:0] sum, len;
		longint qx, qy, qz;
		normal_t r;
		ex = ax - bx; ey = ay - by; ez = az - bz;
		fx = bx - cx; fy = by - cy; fz = bz - cz;
		kx = ey * fz - fy * ez;
		ky = ez * fx - fz * ex;
		kz = ex * fy - fx * ey;
		sx = 16'(kx >>> FRAC_BITS);
		sy = 16'(ky >>> FRAC_BITS);
		sz = 16'(kz >>> FRAC_BITS);
		sum = 32'(sx) * 32'(sx) + 32'(sy) * 32'(sy) + 32'(sz) * 32'(sz);
		len = floor_sqrt(sum);
		if (len == 0) begin
			r = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
		end else begin
			qx = longint'(kx) / longint'(len);
			qy = longint'(ky) / longint'(len);
			qz = longint'(kz) / longint'(len);
			r = '{16'(qx), 16'(qy), 16'(qz), 1'b0};
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		normal_t want;
		if (!arst_n) begin
			fail_count <= 0;
			pending_count <= 0;
			normal_queue.delete();
		end else begin
			if (start && !busy)
				normal_queue.push_back(face_normal(a_x, a_y, a_z, b_x, b_y, b_z,
					c_x, c_y, c_z));
			if (done) begin
				if (normal_queue.size() == 0) begin
					$error("unexpected result");
					fail_count <= fail_count + 1;
				end else begin
					want = normal_queue.pop_front();
					if (want.nx !== normal_x || want.ny !== normal_y ||
							want.nz !== normal_z || want.zl !== zero_length)
						fail_count <= fail_count + 1;
					if (want.nx !== normal_x)
						$error("normal_x expected %0d got %0d", want.nx, normal_x);
					if (want.ny !== normal_y)
						$error("normal_y expected %0d got %0d", want.ny, normal_y);
					if (want.nz !== normal_z)
						$error("normal_z expected %0d got %0d", want.nz, normal_z);
					if (want.zl !== zero_length)
						$error("zero_length expected %0b got %0b", want.zl,
							zero_length);
				end
			end
			pending_count <= normal_queue.size();
		end
	end
endmodule

// ===== tb/sv/tb_triangle_unit_face_normal.sv =====
// Testbench top for the triangle unit face normal block: drives directed and
// random faces with random gaps and gives the verdict.
// Depends on triangle_unit_face_normal and tb_triangle_unit_face_normal_checker.
module tb_triangle_unit_face_normal;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_FACES = 430;
	localparam int IDLE_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [15:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
	logic done;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic zero_length;
	int fail_count;
	int pending_count;
	int idle_cycles;

	triangle_unit_face_normal i_dut (.*);

	tb_triangle_unit_face_normal_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[triangle_unit_face_normal] ERROR");
			$finish;
		end
	end

	task automatic send_face(logic [15:0] v[9], bit allow_gap);
		int gap;
		{a_x, a_y, a_z} <= {v[0], v[1], v[2]};
		{b_x, b_y, b_z} <= {v[3], v[4], v[5]};
		{c_x, c_y, c_z} <= {v[6], v[7], v[8]};
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (allow_gap && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] edge_value();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] v[9];
		int shape;
		arst_n = 0;
		start = 0;
		{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
		idle_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		v = '{default: 16'h0000};
		send_face(v, 0);
		v = '{16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0000, 16'h0000,
			16'h1000, 16'h1000, 16'h0000};
		send_face(v, 0);
		v = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
			16'h7fff, 16'h8000, 16'h7fff};
		send_face(v, 0);
		v = '{16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 16'h8000, 16'h8000,
			16'h8000, 16'h0000, 16'h7fff};
		send_face(v, 1);
		v = '{16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000,
			16'h0000, 16'h0000, 16'h0001};
		send_face(v, 1);
		v = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
			16'h0000, 16'h0001, 16'h0000};
		send_face(v, 0);
		v = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
			16'h8000, 16'h8000, 16'h8000};
		send_face(v, 0);
		v = '{16'h0000, 16'h0000, 16'h0000, 16'h0010, 16'h0000, 16'h0000,
			16'h0000, 16'h0010, 16'h0000};
		send_face(v, 1);
		for (int k = 0; k < 8; k++) begin
			foreach (v[i]) v[i] = edge_value();
			send_face(v, 1);
		end
		start <= 1'b0;
		while (pending_count != 0) @(posedge clk);

		for (int n = 0; n < RANDOM_FACES; n++) begin
			shape = $urandom_range(0, 9);
			foreach (v[i]) begin
				if (shape < 5)
					v[i] = 16'($urandom);
				else if (shape < 7)
					v[i] = 16'($signed($urandom_range(0, 4095)) - 2048);
				else if (shape < 8)
					v[i] = 16'($signed($urandom_range(0, 15)) - 8);
				else
					v[i] = edge_value();
			end
			if (shape == 9)
				v[3:5] = v[0:2];
			send_face(v, n < RANDOM_FACES - 60);
		end
		start <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (fail_count == 0)
			$display("[triangle_unit_face_normal] OK");
		else
			$display("[triangle_unit_face_normal] ERROR");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/tufn_pkg.sv
rtl/tufn_front.sv
rtl/tufn_queue.sv
rtl/tufn_back.sv
rtl/triangle_unit_face_normal.sv
rtl/tufn_checker.sv
tb/sv/tb_triangle_unit_face_normal_checker.sv
tb/sv/tb_triangle_unit_face_normal.sv
